/* rtl/core/tffss_pkg.sv */
// Shared constants for the flip-free step size block.
`default_nettype none
package tffss_pkg;

	localparam logic OP_LOAD     = 1'b0;
	localparam logic OP_TRIANGLE = 1'b1;

	localparam logic [31:0] TOL_RESET = 32'd4295;

	localparam int QW        = 32;
	localparam int FRAC_BITS = 16;
	localparam int RAD_BITS  = 32;

	localparam logic [3:0] PROD_LAST = 4'd9;

endpackage
`default_nettype wire

/* rtl/core/tffss_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module tffss_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* rtl/core/tffss_mul.sv */
// Signed serial multiplier, four multiplier bits per cycle.
`default_nettype none
module tffss_mul #(
	parameter int W = 69
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic                  done,
	output logic signed [2*W-1:0] p
);

	localparam int ND   = (W + 3) / 4;
	localparam int PADW = 4 * ND;
	localparam int CNTW = $clog2(ND + 1);

	logic [W-1:0]          am_q;
	logic [PADW-1:0]       bm_q;
	logic                  neg_q;
	logic [2*W-1:0]        acc_q;
	logic [CNTW-1:0]       cnt_q;
	logic                  run_q;
	logic                  fix_q;
	logic                  done_q;
	logic signed [2*W-1:0] p_q;
	logic [W-1:0]          a_mag;
	logic [W-1:0]          b_mag;
	logic [W+3:0]          pp;

	assign a_mag = a[W-1] ? W'(-a) : W'(a);
	assign b_mag = b[W-1] ? W'(-b) : W'(b);
	assign pp    = {4'b0, am_q} * {{W{1'b0}}, bm_q[PADW-1 -: 4]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CNTW'(ND);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					run_q <= 1'b0;
					fix_q <= 1'b1;
				end
			end else if (fix_q) begin
				fix_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			am_q  <= a_mag;
			bm_q  <= PADW'(b_mag);
			neg_q <= a[W-1] ^ b[W-1];
			acc_q <= '0;
		end else if (run_q) begin
			acc_q <= {acc_q[2*W-5:0], 4'b0} + {{(W-4){1'b0}}, pp};
			bm_q  <= {bm_q[PADW-5:0], 4'b0};
		end else if (fix_q) begin
			p_q <= neg_q ? -$signed(acc_q) : $signed(acc_q);
		end
	end

	assign done = done_q;
	assign p    = p_q;

endmodule
`default_nettype wire

/* rtl/core/tffss_sqrt.sv */
// Bit-serial integer square root, one root bit per cycle.
`default_nettype none
module tffss_sqrt #(
	parameter int XW = 170
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [XW-1:0]     x,
	output logic              done,
	output logic [XW/2-1:0]   root
);

	localparam int RW   = XW / 2;
	localparam int CNTW = $clog2(RW + 1);

	logic [XW-1:0]   xs_q;
	logic [RW-1:0]   root_q;
	logic [RW+1:0]   rem_q;
	logic [CNTW-1:0] cnt_q;
	logic            run_q;
	logic            done_q;
	logic [RW+3:0]   remc;
	logic [RW+3:0]   trial;
	logic            take;

	assign remc  = {rem_q, xs_q[XW-1 -: 2]};
	assign trial = {2'b0, root_q, 2'b01};
	assign take  = (remc >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CNTW'(RW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			xs_q   <= x;
			root_q <= '0;
			rem_q  <= '0;
		end else if (run_q) begin
			xs_q   <= {xs_q[XW-3:0], 2'b0};
			root_q <= {root_q[RW-2:0], take};
			rem_q  <= take ? (RW+2)'(remc - trial) : (RW+2)'(remc);
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

/* rtl/core/tffss_div.sv */
// Restoring divider for a 32-bit quotient, held at 2^32 when it overflows.
`default_nettype none
module tffss_div
	import tffss_pkg::*;
#(
	parameter int NW = 87,
	parameter int EW = 70
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [NW-1:0] n,
	input  logic [EW-1:0] e,
	output logic          done,
	output logic [QW:0]   q
);

	localparam int DVW  = ((NW > EW + QW) ? NW : EW + QW) + 1;
	localparam int CNTW = $clog2(QW + 1);

	logic [DVW-1:0]  rem_q;
	logic [DVW-1:0]  dsr_q;
	logic [QW:0]     q_q;
	logic [CNTW-1:0] cnt_q;
	logic            chk_q;
	logic            run_q;
	logic            done_q;
	logic            ge;

	assign ge = (rem_q >= dsr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_q  <= 1'b0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				chk_q <= 1'b1;
			end else if (chk_q) begin
				chk_q <= 1'b0;
				if (ge) begin
					done_q <= 1'b1;
				end else begin
					run_q <= 1'b1;
					cnt_q <= CNTW'(QW);
				end
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= DVW'(n);
			dsr_q <= DVW'(e) << QW;
			q_q   <= '0;
		end else if (chk_q) begin
			if (ge) begin
				q_q <= {1'b1, {QW{1'b0}}};
			end
			dsr_q <= dsr_q >> 1;
		end else if (run_q) begin
			if (ge) begin
				rem_q <= rem_q - dsr_q;
			end
			q_q   <= {q_q[QW-1:0], ge};
			dsr_q <= dsr_q >> 1;
		end
	end

	assign done = done_q;
	assign q    = q_q;

endmodule
`default_nettype wire

/* rtl/core/triangle_flip_free_step_size.sv */
// Flip-free step size top level: vertex memory, coefficient sequencer and root solver.
// A vertex load (op 0) writes an in-range slot of the vertex memory and busy stays low. A triangle (op 1) reads its
// three corners from the vertex memory (states RD0 to RD3), forms the area quadratic with ten
// products on a serial multiplier (four bits per cycle), takes a bit-serial square root when the
// quadratic is not linear and its discriminant is positive, and at most one serial division, busy high throughout.
// The result of a pass appears with done for one cycle after the last triangle; the
// receiver cannot stall it. Configuration writes are always ready.
`default_nettype none
module triangle_flip_free_step_size
	import tffss_pkg::*;
#(
	parameter int VERTEX_COUNT = 1024,
	parameter int COORD_WIDTH  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [9:0]  vertex_slot,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] move_x,
	input  logic [31:0] move_y,
	input  logic [9:0]  corner_first,
	input  logic [9:0]  corner_second,
	input  logic [9:0]  corner_third,
	input  logic        last_triangle,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output logic        done,
	output logic [31:0] step_size,
	output logic        root_found,
	output logic        saturated
);

	localparam int CW  = COORD_WIDTH;
	localparam int AW  = $clog2(VERTEX_COUNT);
	localparam int VW  = 4 * CW;
	localparam int CFW = 2 * CW + 5;
	localparam int PW  = 2 * CFW;
	localparam int XW  = PW + RAD_BITS;
	localparam int RW  = XW / 2;
	localparam int NW  = CFW + 18;
	localparam int EW  = CFW + 1;
	localparam logic [16:0] VC = 17'(VERTEX_COUNT);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_RD0   = 12'b0000_0000_0010,
		S_RD1   = 12'b0000_0000_0100,
		S_RD2   = 12'b0000_0000_1000,
		S_RD3   = 12'b0000_0001_0000,
		S_MUL   = 12'b0000_0010_0000,
		S_CLASS = 12'b0000_0100_0000,
		S_PICK  = 12'b0000_1000_0000,
		S_SQRT  = 12'b0001_0000_0000,
		S_TRY   = 12'b0010_0000_0000,
		S_DIV   = 12'b0100_0000_0000,
		S_FIN   = 12'b1000_0000_0000
	} state_t;

	state_t             state_q;
	logic [3:0]         idx_q;
	logic               issued_q;
	logic               alt_q;
	logic               found_q;
	logic [QW:0]        min_q;
	logic               min_vld_q;
	logic               done_q;
	logic [31:0]        tol_q;
	logic [31:0]        step_q;
	logic               rfound_q;
	logic               sat_q;

	logic [9:0]         c0_q, c1_q, c2_q;
	logic               last_q;
	logic [VW-1:0]      v0_q, v1_q, v2_q;
	logic signed [CFW-1:0] a_q, b_q, c_q;
	logic signed [PW-1:0]  bb_q, ac_q, d_q;
	logic               lin_q;
	logic signed [NW-1:0]  n_q, n2_q;
	logic signed [EW-1:0]  e_q;
	logic [QW:0]        q_q;

	logic               accept;
	logic               ram_we;
	logic [AW-1:0]      raddr;
	logic [VW-1:0]      rdata;
	logic               rng0, rng1, rng2;

	logic signed [CW:0] dx1, dy1, dx2, dy2, ex1, ey1, ex2, ey2;
	logic signed [CFW-1:0] op_a, op_b, prod;
	logic               mul_go, mul_done;
	logic signed [PW-1:0]  mul_p;

	logic               sq_go, sq_done;
	logic [RW-1:0]      sq_root;

	logic               div_go, div_done;
	logic [QW:0]        div_q;
	logic [NW-1:0]      n_mag;
	logic [EW-1:0]      e_mag;
	logic [CFW-1:0]     a_mag;
	logic signed [NW-1:0]  c_ext, b_ext, nb, r_ext, n_plus, n_minus;
	logic               n_zero, n_bad, d_pos;
	logic               upd, nvld;
	logic [QW:0]        nmin;

	function automatic logic signed [CW:0] fdiff(input logic [CW-1:0] p, input logic [CW-1:0] s);
		fdiff = $signed({p[CW-1], p}) - $signed({s[CW-1], s});
	endfunction

	function automatic logic signed [CFW-1:0] sx(input logic signed [CW:0] d);
		sx = {{(CFW-CW-1){d[CW]}}, d};
	endfunction

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign ram_we    = accept && (op == OP_LOAD) && ({7'b0, vertex_slot} < VC);

	assign rng0 = ({7'b0, c0_q} < VC);
	assign rng1 = ({7'b0, c1_q} < VC);
	assign rng2 = ({7'b0, c2_q} < VC);

	always_comb begin
		unique case (state_q)
			S_RD1:   raddr = AW'(c1_q);
			S_RD2:   raddr = AW'(c2_q);
			default: raddr = AW'(c0_q);
		endcase
	end

	tffss_ram #(
		.WIDTH(VW),
		.DEPTH(VERTEX_COUNT)
	) u_vram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(vertex_slot)),
		.wdata ({move_y[CW-1:0], move_x[CW-1:0], pos_y[CW-1:0], pos_x[CW-1:0]}),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign dx1 = fdiff(v1_q[CW-1:0],      v0_q[CW-1:0]);
	assign dy1 = fdiff(v1_q[2*CW-1:CW],   v0_q[2*CW-1:CW]);
	assign ex1 = fdiff(v1_q[3*CW-1:2*CW], v0_q[3*CW-1:2*CW]);
	assign ey1 = fdiff(v1_q[4*CW-1:3*CW], v0_q[4*CW-1:3*CW]);
	assign dx2 = fdiff(v2_q[CW-1:0],      v0_q[CW-1:0]);
	assign dy2 = fdiff(v2_q[2*CW-1:CW],   v0_q[2*CW-1:CW]);
	assign ex2 = fdiff(v2_q[3*CW-1:2*CW], v0_q[3*CW-1:2*CW]);
	assign ey2 = fdiff(v2_q[4*CW-1:3*CW], v0_q[4*CW-1:3*CW]);

	always_comb begin
		case (idx_q)
			4'd0:    begin op_a = sx(ex1); op_b = sx(ey2); end
			4'd1:    begin op_a = sx(ex2); op_b = sx(ey1); end
			4'd2:    begin op_a = sx(dx1); op_b = sx(ey2); end
			4'd3:    begin op_a = sx(ex1); op_b = sx(dy2); end
			4'd4:    begin op_a = sx(dx2); op_b = sx(ey1); end
			4'd5:    begin op_a = sx(ex2); op_b = sx(dy1); end
			4'd6:    begin op_a = sx(dx1); op_b = sx(dy2); end
			4'd7:    begin op_a = sx(dx2); op_b = sx(dy1); end
			4'd8:    begin op_a = b_q;     op_b = b_q;     end
			default: begin op_a = a_q;     op_b = c_q;     end
		endcase
	end

	assign mul_go = (state_q == S_MUL) && !issued_q;
	assign prod   = mul_p[CFW-1:0];

	tffss_mul #(.W(CFW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go),
		.a      (op_a),
		.b      (op_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	assign a_mag   = a_q[CFW-1] ? CFW'(-a_q) : CFW'(a_q);
	assign d_pos   = !d_q[PW-1] && (d_q != '0);
	assign sq_go   = (state_q == S_PICK) && !lin_q && d_pos;

	tffss_sqrt #(.XW(XW)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (sq_go),
		.x      ({d_q, {RAD_BITS{1'b0}}}),
		.done   (sq_done),
		.root   (sq_root)
	);

	assign c_ext   = {{(NW-CFW){c_q[CFW-1]}}, c_q};
	assign b_ext   = {{(NW-CFW){b_q[CFW-1]}}, b_q};
	assign nb      = -(b_ext <<< FRAC_BITS);
	assign r_ext   = $signed({{(NW-RW){1'b0}}, sq_root});
	assign n_plus  = nb + r_ext;
	assign n_minus = nb - r_ext;

	assign n_zero  = (n_q == '0);
	assign n_bad   = (n_q[NW-1] != e_q[EW-1]);
	assign n_mag   = n_q[NW-1] ? NW'(-n_q) : NW'(n_q);
	assign e_mag   = e_q[EW-1] ? EW'(-e_q) : EW'(e_q);
	assign div_go  = (state_q == S_TRY) && !n_zero && !n_bad;

	tffss_div #(.NW(NW), .EW(EW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.n      (n_mag),
		.e      (e_mag),
		.done   (div_done),
		.q      (div_q)
	);

	assign upd  = found_q && (!min_vld_q || (q_q < min_q));
	assign nmin = upd ? q_q : min_q;
	assign nvld = min_vld_q || found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			idx_q     <= '0;
			issued_q  <= 1'b0;
			alt_q     <= 1'b0;
			found_q   <= 1'b0;
			min_q     <= '0;
			min_vld_q <= 1'b0;
			done_q    <= 1'b0;
			tol_q     <= TOL_RESET;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				tol_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start && op == OP_TRIANGLE) begin
						state_q <= S_RD0;
					end
				end
				S_RD0: state_q <= S_RD1;
				S_RD1: state_q <= S_RD2;
				S_RD2: state_q <= S_RD3;
				S_RD3: begin
					state_q  <= S_MUL;
					idx_q    <= '0;
					issued_q <= 1'b0;
				end
				S_MUL: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
					end
					if (mul_done) begin
						issued_q <= 1'b0;
						if (idx_q == PROD_LAST) begin
							state_q <= S_CLASS;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_CLASS: begin
					state_q <= S_PICK;
					found_q <= 1'b0;
				end
				S_PICK: begin
					alt_q <= 1'b0;
					if (lin_q) begin
						state_q <= (b_q == '0) ? S_FIN : S_TRY;
					end else begin
						state_q <= d_pos ? S_SQRT : S_FIN;
					end
				end
				S_SQRT: begin
					if (sq_done) begin
						alt_q   <= 1'b1;
						state_q <= S_TRY;
					end
				end
				S_TRY: begin
					if (n_zero) begin
						found_q <= 1'b1;
						state_q <= S_FIN;
					end else if (n_bad) begin
						if (alt_q) begin
							alt_q <= 1'b0;
						end else begin
							state_q <= S_FIN;
						end
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						found_q <= 1'b1;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_IDLE;
					if (last_q) begin
						done_q    <= 1'b1;
						min_q     <= '0;
						min_vld_q <= 1'b0;
					end else begin
						min_q     <= nmin;
						min_vld_q <= nvld;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && op == OP_TRIANGLE) begin
			c0_q   <= corner_first;
			c1_q   <= corner_second;
			c2_q   <= corner_third;
			last_q <= last_triangle;
			a_q    <= '0;
			b_q    <= '0;
			c_q    <= '0;
		end
		if (state_q == S_RD1) begin
			v0_q <= rng0 ? rdata : '0;
		end
		if (state_q == S_RD2) begin
			v1_q <= rng1 ? rdata : '0;
		end
		if (state_q == S_RD3) begin
			v2_q <= rng2 ? rdata : '0;
		end
		if (state_q == S_MUL && mul_done) begin
			case (idx_q) inside
				4'd0:       a_q  <= a_q + prod;
				4'd1:       a_q  <= a_q - prod;
				4'd2, 4'd3: b_q  <= b_q + prod;
				4'd4, 4'd5: b_q  <= b_q - prod;
				4'd6:       c_q  <= c_q + prod;
				4'd7:       c_q  <= c_q - prod;
				4'd8:       bb_q <= mul_p;
				default:    ac_q <= mul_p;
			endcase
		end
		if (state_q == S_CLASS) begin
			lin_q <= (a_mag <= {{(CFW-32){1'b0}}, tol_q});
			d_q   <= bb_q - (ac_q <<< 2);
		end
		if (state_q == S_PICK) begin
			n_q <= -(c_ext <<< FRAC_BITS);
			e_q <= {b_q[CFW-1], b_q};
		end
		if (state_q == S_SQRT && sq_done) begin
			n_q  <= a_q[CFW-1] ? n_plus : n_minus;
			n2_q <= a_q[CFW-1] ? n_minus : n_plus;
			e_q  <= {a_q, 1'b0};
		end
		if (state_q == S_TRY) begin
			if (n_zero) begin
				q_q <= '0;
			end else if (n_bad && alt_q) begin
				n_q <= n2_q;
			end
		end
		if (state_q == S_DIV && div_done) begin
			q_q <= div_q;
		end
		if (state_q == S_FIN && last_q) begin
			step_q   <= nvld ? (nmin[QW] ? {QW{1'b1}} : nmin[QW-1:0]) : '0;
			rfound_q <= nvld;
			sat_q    <= nvld && nmin[QW];
		end
	end

	assign done       = done_q;
	assign step_size  = step_q;
	assign root_found = rfound_q;
	assign saturated  = sat_q;

endmodule
`default_nettype wire
